/* sv/cluster_bitmap_allocator_macros.svh */
// ----------------------------------------------------------------------------
// cluster bitmap allocator assertion macros
// shared property wrappers for the allocator checks
// ----------------------------------------------------------------------------
`ifndef CLUSTER_BITMAP_ALLOCATOR_MACROS_SVH
`define CLUSTER_BITMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define CBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cluster bitmap allocator check failed");

// next-cycle implication
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cluster bitmap allocator check failed");

`endif

/* sv/cba_pkg.sv */
// ----------------------------------------------------------------------------
// cba_pkg
// types and constants shared by the cluster bitmap allocator
// ----------------------------------------------------------------------------
package cba_pkg;

   localparam int CLUSTER_WIDTH    = 17;
   localparam int CLUSTER_LIMIT    = (1 << CLUSTER_WIDTH) - 1;
   localparam int LOWEST_CLUSTER   = 2;
   localparam int DEF_MAX_CLUSTERS = 65536;
   localparam int DEF_WORD_BITS    = 32;
   localparam int CSR_RESET        = 65536;

   typedef enum logic [1:0] {
      OP_QUERY     = 2'd0,
      OP_MARK_USED = 2'd1,
      OP_MARK_FREE = 2'd2,
      OP_FIND_FREE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_NO_SPACE = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic [CLUSTER_WIDTH-1:0] cluster_number;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic                     used_bit;
      logic [CLUSTER_WIDTH-1:0] found_cluster;
   } rsp_type;

endpackage

/* sv/cluster_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// cluster_bitmap_allocator: first-fit cluster bitmap, one word read a cycle
// query/mark: accept, then S_READ and S_EVAL; rsp_valid registered from S_EVAL
// find: S_READ, then S_SCAN word by word to a hit or the end; rsp_valid from S_SCAN
// range or no-space rejects at accept: rsp_valid in the next cycle, busy stays low
// reset clears all WORD_COUNT words (2048 by default) in S_CLEAR; busy stays high
// word and bit index by shift and mask (WORD_BITS a power of two); no rsp stall
// ----------------------------------------------------------------------------
module cluster_bitmap_allocator
   import cba_pkg::*;
#(
   parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
   parameter int WORD_BITS    = DEF_WORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CLUSTER_WIDTH-1:0] csr_wdata
);

   localparam int CW         = CLUSTER_WIDTH;
   localparam int WORD_COUNT = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BW         = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int CAP        = (MAX_CLUSTERS > CLUSTER_LIMIT) ? CLUSTER_LIMIT : MAX_CLUSTERS;
   localparam logic [CW-1:0] CNT_CAP   = CW'(CAP);
   localparam logic [CW-1:0] CNT_RESET = CW'((CSR_RESET > CAP) ? CAP : CSR_RESET);
   localparam logic [CW-1:0] LOW_CL    = CW'(LOWEST_CLUSTER);
   localparam logic [CW-1:0] WB_CL     = CW'(WORD_BITS);
   localparam logic [AW-1:0] LAST_WORD = AW'(WORD_COUNT - 1);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_READ  = 5'b00100,
      S_EVAL  = 5'b01000,
      S_SCAN  = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   op_type          op_ff, op_in;
   logic [AW-1:0]   word_ff, word_in;
   logic [BW-1:0]   bit_ff, bit_in;
   logic [CW-1:0]   base_ff, base_in;
   logic            first_ff, first_in;
   logic [CW-1:0]   clusters_ff, clusters_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [AW-1:0]        mem_raddr;

   logic                 below_first;
   logic [CW-1:0]        req_idx;
   logic [WORD_BITS-1:0] bit_mask;
   logic [WORD_BITS-1:0] new_word;
   logic [WORD_BITS-1:0] free_bits;
   logic                 hit;
   logic [BW-1:0]        hit_idx;
   logic [CW-1:0]        hit_pos;
   logic [CW:0]          next_base;
   logic                 rsp_error;
   logic                 rsp_fields_clear;
   logic                 rsp_found;
   logic                 found_in_window;

   // bitmap store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[word_ff] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign mem_raddr = (state_ff == S_SCAN) ? word_ff + AW'(1) : word_ff;

   // word update for query and mark
   assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_ff;

   always_comb begin
      case (op_ff)
         OP_MARK_USED: new_word = rd_data_ff | bit_mask;
         OP_MARK_FREE: new_word = rd_data_ff & ~bit_mask;
         default:      new_word = rd_data_ff;
      endcase
   end

   // lowest free bit in the current word
   always_comb begin
      free_bits = ~rd_data_ff;
      if (first_ff) begin
         free_bits = free_bits & ({WORD_BITS{1'b1}} << bit_ff);
      end
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            hit     = 1'b1;
            hit_idx = BW'(i);
         end
      end
   end

   assign hit_pos   = base_ff + CW'(hit_idx);
   assign next_base = {1'b0, base_ff} + {1'b0, WB_CL};

   assign below_first = (req_data.cluster_number < LOW_CL);
   assign req_idx     = below_first ? '0 : req_data.cluster_number - LOW_CL;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      word_in      = word_ff;
      bit_in       = bit_ff;
      base_in      = base_ff;
      first_in     = first_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wdata    = new_word;

      if (csr_we) begin
         clusters_in = (csr_wdata > CNT_CAP) ? CNT_CAP : csr_wdata;
      end else begin
         clusters_in = clusters_ff;
      end

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            if (word_ff == LAST_WORD) begin
               word_in  = '0;
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in    = req_data.op;
               word_in  = AW'(req_idx[CW-1:BW]);
               bit_in   = req_idx[BW-1:0];
               base_in  = {req_idx[CW-1:BW], {BW{1'b0}}};
               first_in = 1'b1;
               if (req_data.op == OP_FIND_FREE) begin
                  if (req_idx >= clusters_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ST_NO_SPACE, used_bit: 1'b0, found_cluster: '0};
                  end else begin
                     state_in = S_READ;
                  end
               end else if (below_first || req_idx >= clusters_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ST_RANGE, used_bit: 1'b0, found_cluster: '0};
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = (op_ff == OP_FIND_FREE) ? S_SCAN : S_EVAL;
         end
         S_EVAL: begin
            mem_we       = (op_ff == OP_MARK_USED) || (op_ff == OP_MARK_FREE);
            rsp_valid_in = 1'b1;
            rsp_in       = '{status: ST_OK, used_bit: new_word[bit_ff], found_cluster: '0};
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            first_in = 1'b0;
            if (hit) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (hit_pos >= clusters_ff) begin
                  rsp_in = '{status: ST_NO_SPACE, used_bit: 1'b0, found_cluster: '0};
               end else begin
                  rsp_in = '{status: ST_OK, used_bit: 1'b0, found_cluster: hit_pos + LOW_CL};
               end
            end else if (next_base >= {1'b0, clusters_ff}) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ST_NO_SPACE, used_bit: 1'b0, found_cluster: '0};
               state_in     = S_IDLE;
            end else begin
               word_in = word_ff + AW'(1);
               base_in = next_base[CW-1:0];
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         first_ff     <= 1'b0;
         clusters_ff  <= CNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         first_ff     <= first_in;
         clusters_ff  <= clusters_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      bit_ff  <= bit_in;
      base_ff <= base_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rsp_error        = rsp_valid && (rsp_data.status != ST_OK);
   assign rsp_fields_clear = !rsp_data.used_bit && (rsp_data.found_cluster == '0);
   assign rsp_found        = rsp_valid && (rsp_data.found_cluster != '0);
   assign found_in_window  = (rsp_data.found_cluster >= LOW_CL) &&
                             ((rsp_data.found_cluster - LOW_CL) < clusters_ff);

`include "cluster_bitmap_allocator_macros.svh"

   `CBA_ASSERT_NEXT(a_accept_goes_busy_or_responds, clock, reset, start && !busy, busy || rsp_valid)
   `CBA_ASSERT_NOW(a_rsp_follows_work, clock, reset, rsp_valid && !$past(start), $past(busy))
   `CBA_ASSERT_NOW(a_error_rsp_clean, clock, reset, rsp_error, rsp_fields_clear)
   `CBA_ASSERT_NOW(a_found_in_range, clock, reset, rsp_found, found_in_window)

endmodule
